// ----- rtl/mfm_pkg.sv -----
// Package with types, fault codes and constants for the motor fault monitor.
package mfm_pkg;

    localparam logic [2:0] CODE_NONE = 3'd0;
    localparam logic [2:0] CODE_OC   = 3'd1;
    localparam logic [2:0] CODE_OV   = 3'd2;
    localparam logic [2:0] CODE_UV   = 3'd3;
    localparam logic [2:0] CODE_SW   = 3'd4;
    localparam logic [2:0] CODE_WD   = 3'd5;

    localparam logic [2:0] REG_CURRENT_LIMIT = 3'd0;
    localparam logic [2:0] REG_OVERVOLT      = 3'd1;
    localparam logic [2:0] REG_UNDERVOLT     = 3'd2;
    localparam logic [2:0] REG_SW_TRIP       = 3'd3;
    localparam logic [2:0] REG_SW_WARN       = 3'd4;
    localparam logic [2:0] REG_WD_TRIP       = 3'd5;
    localparam logic [2:0] REG_WD_WARN       = 3'd6;
    localparam logic [2:0] REG_HYST          = 3'd7;

    localparam int SUM_W = 20;
    localparam int IN_W  = 88;
    localparam int OUT_W = 104;

    // Per-sensor temperature verdicts.
    typedef struct packed {
        logic hot;
        logic warm;
        logic hot_clear;
        logic warm_clear;
    } temp_flags_t;

endpackage

// ----- rtl/mfm_lane.sv -----
// One averaging lane: sliding window of samples and its registered sum.
module mfm_lane #(
    parameter int DEPTH  = 3,
    parameter int SMP_W  = 16,
    parameter int SLOT_W = 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  logic [SLOT_W-1:0]                  slot,
    input  logic signed [SMP_W-1:0]            sample,
    input  logic                               sample_signed,
    output logic signed [mfm_pkg::SUM_W-1:0]   win_sum
);
    import mfm_pkg::*;

    logic signed [SUM_W-1:0] win_reg [DEPTH];
    logic signed [SUM_W-1:0] ext;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;

    assign ext = sample_signed ? SUM_W'(sample) : SUM_W'($unsigned(sample));

    always_comb
    begin
        sum_next = sum_reg - win_reg[slot] + ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                win_reg[i] <= '0;
            end
            sum_reg <= '0;
        end
        else if (load)
        begin
            win_reg[slot] <= ext;
            sum_reg       <= sum_next;
        end
    end

    assign win_sum = sum_next;
endmodule

// ----- rtl/mfm_merge.sv -----
// Merge stage: debounce counters, fault and warning stores, captured averages.
module mfm_merge #(
    parameter int DEPTH     = 3,
    parameter int CUR_TICKS = 10,
    parameter int OTH_TICKS = 3
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic [14:0]                      current_limit,
    input  logic [15:0]                      overvolt_limit,
    input  logic [15:0]                      undervolt_limit,
    input  logic signed [11:0]               sw_trip,
    input  logic signed [11:0]               sw_warn,
    input  logic signed [11:0]               wd_trip,
    input  logic signed [11:0]               wd_warn,
    input  logic [8:0]                       hyst,
    input  logic signed [mfm_pkg::SUM_W-1:0] sa,
    input  logic signed [mfm_pkg::SUM_W-1:0] sb,
    input  logic signed [mfm_pkg::SUM_W-1:0] sc,
    input  logic signed [mfm_pkg::SUM_W-1:0] sv,
    input  logic signed [mfm_pkg::SUM_W-1:0] ss,
    input  logic signed [mfm_pkg::SUM_W-1:0] sw,
    output logic [mfm_pkg::OUT_W-1:0]        result
);
    import mfm_pkg::*;

    localparam int PW = SUM_W + 6;

    // Averages are taken by multiplying the sum magnitude with a rounded-up reciprocal.
    localparam int DIV_K = SUM_W - 1 + $clog2(DEPTH);
    localparam int DIV_M = ((1 << DIV_K) + DEPTH - 1) / DEPTH;
    localparam int DIV_W = SUM_W + DIV_K;

    logic [3:0] oc_cnt_reg, oc_cnt_next;
    logic [2:0] ov_cnt_reg, ov_cnt_next, uv_cnt_reg, uv_cnt_next;
    logic [2:0] t_cnt_reg [4];
    logic [2:0] t_cnt_next [4];
    logic [4:0] fault_reg, fault_next;
    logic [1:0] warn_reg, warn_next;
    logic [2:0] act_reg, act_next, last_reg, last_next;
    logic [15:0] h_a_reg, h_a_next, h_b_reg, h_b_next, h_c_reg, h_c_next, h_v_reg, h_v_next;
    logic [11:0] h_s_reg, h_s_next, h_w_reg, h_w_next;
    logic kill;

    logic signed [PW-1:0] lim_c, lim_ov, lim_uv;
    logic signed [PW-1:0] tl [4];
    logic signed [PW-1:0] cl [4];
    logic signed [PW-1:0] tsum [2];
    logic signed [11:0] tlev [4];

    function automatic logic signed [PW-1:0] mul_d(input logic signed [PW-1:0] v);
        mul_d = PW'(v * DEPTH);
    endfunction

    function automatic logic signed [15:0] div_d(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] mag;
        logic [DIV_W-1:0] prod;
        logic [SUM_W-1:0] q;
        mag   = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
        prod  = DIV_W'(mag) * DIV_W'(DIV_M);
        q     = prod[DIV_K +: SUM_W];
        q     = s[SUM_W-1] ? SUM_W'(-q) : q;
        div_d = q[15:0];
    endfunction

    assign tlev[0] = sw_trip;
    assign tlev[1] = sw_warn;
    assign tlev[2] = wd_trip;
    assign tlev[3] = wd_warn;
    assign tsum[0] = PW'(ss);
    assign tsum[1] = PW'(sw);

    always_comb
    begin
        lim_c  = mul_d(PW'($unsigned(current_limit)));
        lim_ov = mul_d(PW'($unsigned(overvolt_limit)));
        lim_uv = mul_d(PW'($unsigned(undervolt_limit)));
        for (int i = 0; i < 4; i++)
        begin
            tl[i] = mul_d(PW'(tlev[i]));
            cl[i] = mul_d(PW'(tlev[i]) - PW'($unsigned(hyst)));
        end
    end

    always_comb
    begin
        oc_cnt_next = oc_cnt_reg;
        ov_cnt_next = ov_cnt_reg;
        uv_cnt_next = uv_cnt_reg;
        for (int i = 0; i < 4; i++)
        begin
            t_cnt_next[i] = t_cnt_reg[i];
        end
        fault_next = fault_reg;
        warn_next  = warn_reg;
        act_next   = act_reg;
        last_next  = last_reg;
        h_a_next = h_a_reg;
        h_b_next = h_b_reg;
        h_c_next = h_c_reg;
        h_v_next = h_v_reg;
        h_s_next = h_s_reg;
        h_w_next = h_w_reg;
        kill = 1'b0;

        if (PW'(sa) > lim_c || -PW'(sa) > lim_c || PW'(sb) > lim_c || -PW'(sb) > lim_c
            || PW'(sc) > lim_c || -PW'(sc) > lim_c)
        begin
            oc_cnt_next = (oc_cnt_reg == 4'd15) ? 4'd15 : oc_cnt_reg + 4'd1;
            if (oc_cnt_next > 4'(CUR_TICKS))
            begin
                fault_next[0] = 1'b1;
                act_next = CODE_OC;
                last_next = CODE_OC;
                kill = 1'b1;
                h_a_next = div_d(sa);
                h_b_next = div_d(sb);
                h_c_next = div_d(sc);
            end
        end
        else
        begin
            oc_cnt_next = '0;
            if (act_reg == CODE_OC)
            begin
                act_next = CODE_NONE;
            end
        end

        if (PW'(sv) > lim_ov)
        begin
            ov_cnt_next = (ov_cnt_reg == 3'd7) ? 3'd7 : ov_cnt_reg + 3'd1;
            if (ov_cnt_next > 3'(OTH_TICKS))
            begin
                fault_next[1] = 1'b1;
                act_next = CODE_OV;
                last_next = CODE_OV;
                kill = 1'b1;
                h_v_next = div_d(sv);
            end
        end
        else if (PW'(sv) < lim_uv)
        begin
            uv_cnt_next = (uv_cnt_reg == 3'd7) ? 3'd7 : uv_cnt_reg + 3'd1;
            if (uv_cnt_next > 3'(OTH_TICKS))
            begin
                fault_next[2] = 1'b1;
                act_next = CODE_UV;
                last_next = CODE_UV;
                kill = 1'b1;
                h_v_next = div_d(sv);
            end
        end
        else
        begin
            ov_cnt_next = '0;
            uv_cnt_next = '0;
            if (act_next == CODE_OV || act_next == CODE_UV)
            begin
                act_next = CODE_NONE;
            end
        end

        for (int k = 0; k < 2; k++)
        begin
            if (tsum[k] > tl[2*k])
            begin
                t_cnt_next[2*k] = (t_cnt_reg[2*k] == 3'd7) ? 3'd7 : t_cnt_reg[2*k] + 3'd1;
                if (t_cnt_next[2*k] > 3'(OTH_TICKS))
                begin
                    fault_next[3+k] = 1'b1;
                    act_next = (k == 0) ? CODE_SW : CODE_WD;
                    last_next = act_next;
                    kill = 1'b1;
                    if (k == 0)
                    begin
                        h_s_next = 12'(div_d(ss));
                    end
                    else
                    begin
                        h_w_next = 12'(div_d(sw));
                    end
                end
            end
            else if (tsum[k] > tl[2*k+1])
            begin
                t_cnt_next[2*k+1] = (t_cnt_reg[2*k+1] == 3'd7) ? 3'd7
                                                              : t_cnt_reg[2*k+1] + 3'd1;
                if (t_cnt_next[2*k+1] > 3'(OTH_TICKS))
                begin
                    warn_next[k] = 1'b1;
                end
            end
            else
            begin
                if (tsum[k] < cl[2*k])
                begin
                    t_cnt_next[2*k] = '0;
                    if (act_next == ((k == 0) ? CODE_SW : CODE_WD))
                    begin
                        act_next = CODE_NONE;
                    end
                end
                if (tsum[k] < cl[2*k+1])
                begin
                    t_cnt_next[2*k+1] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oc_cnt_reg <= '0;
            ov_cnt_reg <= '0;
            uv_cnt_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                t_cnt_reg[i] <= '0;
            end
            fault_reg <= '0;
            warn_reg  <= '0;
            act_reg   <= CODE_NONE;
            last_reg  <= CODE_NONE;
            h_a_reg <= '0;
            h_b_reg <= '0;
            h_c_reg <= '0;
            h_v_reg <= '0;
            h_s_reg <= '0;
            h_w_reg <= '0;
            result  <= '0;
        end
        else if (step)
        begin
            oc_cnt_reg <= oc_cnt_next;
            ov_cnt_reg <= ov_cnt_next;
            uv_cnt_reg <= uv_cnt_next;
            for (int i = 0; i < 4; i++)
            begin
                t_cnt_reg[i] <= t_cnt_next[i];
            end
            fault_reg <= fault_next;
            warn_reg  <= warn_next;
            act_reg   <= act_next;
            last_reg  <= last_next;
            h_a_reg <= h_a_next;
            h_b_reg <= h_b_next;
            h_c_reg <= h_c_next;
            h_v_reg <= h_v_next;
            h_s_reg <= h_s_next;
            h_w_reg <= h_w_next;
            result <= OUT_W'({h_w_next, h_s_next, h_v_next, h_c_next, h_b_next, h_a_next,
                              last_next, act_next, warn_next, fault_next, kill});
        end
    end
endmodule

// ----- rtl/motor_fault_monitor.sv -----
// Top level of the motor fault monitor: stream ports, configuration and lanes.
// The monitor takes one beat per clock cycle while results are taken, and delivers its result beat
// in the cycle after acceptance; the six averaging lanes and the merge stage run in one pass. The
// single output register lets the next beat enter in the same cycle that the waiting
// result is taken; a result that is not taken stalls the input until it is.
// Fault decisions compare window sums exactly against limit times AVG_DEPTH.
module motor_fault_monitor #(
    parameter int AVG_DEPTH          = 3,
    parameter int CURRENT_TRIP_TICKS = 10,
    parameter int OTHER_TRIP_TICKS   = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // current_a, current_b, current_c, bus_voltage, switch_temp, winding_temp
    input  logic [mfm_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pwm_kill, fault_bits, warning_bits, active_fault, latest_fault, held_current_a,
    // held_current_b, held_current_c, held_bus_voltage, held_switch_temp,
    // held_winding_temp, zero fill
    output logic [mfm_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [15:0]                   cfg_data
);
    import mfm_pkg::*;

    localparam int SLOT_W = $clog2(AVG_DEPTH);

    logic [14:0] cur_lim_reg;
    logic [15:0] ov_lim_reg, uv_lim_reg;
    logic signed [11:0] sw_trip_reg, sw_warn_reg, wd_trip_reg, wd_warn_reg;
    logic [8:0] hyst_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic valid_reg;
    logic step;
    logic signed [SUM_W-1:0] sums [6];
    logic [OUT_W-1:0] res;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !valid_reg || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_lim_reg <= 15'd32767;
            ov_lim_reg  <= 16'd6000;
            uv_lim_reg  <= 16'd2400;
            sw_trip_reg <= 12'sd1000;
            sw_warn_reg <= 12'sd900;
            wd_trip_reg <= 12'sd1000;
            wd_warn_reg <= 12'sd900;
            hyst_reg    <= 9'd50;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CURRENT_LIMIT: cur_lim_reg <= cfg_data[14:0];
                REG_OVERVOLT:      ov_lim_reg  <= cfg_data;
                REG_UNDERVOLT:     uv_lim_reg  <= cfg_data;
                REG_SW_TRIP:       sw_trip_reg <= cfg_data[11:0];
                REG_SW_WARN:       sw_warn_reg <= cfg_data[11:0];
                REG_WD_TRIP:       wd_trip_reg <= cfg_data[11:0];
                REG_WD_WARN:       wd_warn_reg <= cfg_data[11:0];
                REG_HYST:          hyst_reg    <= cfg_data[8:0];
                default:           hyst_reg    <= hyst_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                slot_reg <= (slot_reg == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
            end
            valid_reg <= step || (valid_reg && !m_axis_tready);
        end
    end

    genvar g;
    generate
        for (g = 0; g < 6; g++)
        begin : g_lane
            localparam int LO = (g < 4) ? 16 * g : 64 + 12 * (g - 4);
            localparam int W  = (g < 4) ? 16 : 12;
            mfm_lane #(
                .DEPTH (AVG_DEPTH),
                .SMP_W (W),
                .SLOT_W(SLOT_W)
            ) u_lane (
                .clk          (clk),
                .rst_n        (rst_n),
                .load         (step),
                .slot         (slot_reg),
                .sample       (s_axis_tdata[LO +: W]),
                .sample_signed(g != 3),
                .win_sum      (sums[g])
            );
        end
    endgenerate

    mfm_merge #(
        .DEPTH    (AVG_DEPTH),
        .CUR_TICKS(CURRENT_TRIP_TICKS),
        .OTH_TICKS(OTHER_TRIP_TICKS)
    ) u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .current_limit  (cur_lim_reg),
        .overvolt_limit (ov_lim_reg),
        .undervolt_limit(uv_lim_reg),
        .sw_trip        (sw_trip_reg),
        .sw_warn        (sw_warn_reg),
        .wd_trip        (wd_trip_reg),
        .wd_warn        (wd_warn_reg),
        .hyst           (hyst_reg),
        .sa             (sums[0]),
        .sb             (sums[1]),
        .sc             (sums[2]),
        .sv             (sums[3]),
        .ss             (sums[4]),
        .sw             (sums[5]),
        .result         (res)
    );
endmodule
